/* hdl/assert_macros.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UMSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/umsc_pkg.sv */
// Types and constants for the bulk-only transport sequencer.
package umsc_pkg;

  localparam logic [15:0] CBW_LENGTH = 16'd31;
  localparam logic [31:0] CBW_SIG    = 32'h4342_5355;

  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
  localparam logic [7:0] REQ_MAX_LUN        = 8'hFE;
  localparam logic [7:0] REQ_RESET          = 8'hFF;
  localparam logic [15:0] FEAT_ENDPOINT_HALT = 16'h0000;

  localparam logic [1:0] OP_POLL   = 2'd0;
  localparam logic [1:0] OP_CMD    = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_SETUP  = 2'd3;

  localparam logic [2:0] XFER_OK      = 3'd0;
  localparam logic [2:0] XFER_PENDING = 3'd1;

  localparam logic [1:0] CSW_KEEP        = 2'd0;
  localparam logic [1:0] CSW_FAILED      = 2'd1;
  localparam logic [1:0] CSW_PHASE_ERROR = 2'd2;

  localparam logic [1:0] CTRL_NONE    = 2'd0;
  localparam logic [1:0] CTRL_ZLP     = 2'd1;
  localparam logic [1:0] CTRL_MAX_LUN = 2'd2;
  localparam logic [1:0] CTRL_STALL   = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CBW_READ  = 3'd1;
  localparam logic [2:0] ERR_CBW_SIZE  = 3'd2;
  localparam logic [2:0] ERR_CBW_SIG   = 3'd3;
  localparam logic [2:0] ERR_CSW_WRITE = 3'd4;

  localparam logic [2:0] CCASE_STALL_IN  = 3'd1;
  localparam logic [2:0] CCASE_STALL_OUT = 3'd2;
  localparam logic [2:0] CCASE_PHASE_ERR = 3'd4;

  localparam logic [2:0] REG_ADDR_MAX_LUN = 3'd0;

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_READCBW = 3'd2,
    PH_WAITCBW = 3'd3,
    PH_PROCESS = 3'd4,
    PH_SENDCSW = 3'd5,
    PH_WAITCSW = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   recovery;
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        link_awake;
    logic        link_configured;
    logic [2:0]  xfer_status;
    logic [15:0] xfer_bytes;
    logic [31:0] cbw_signature;
    logic [2:0]  command_case;
    logic        in_halted;
    logic [7:0]  setup_request;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } in_beat_t;

  typedef struct packed {
    logic       link_ready;
    logic       command_ready;
    logic       status_done;
    logic       start_cbw_read;
    logic       start_csw_write;
    logic       halt_in_ep;
    logic       halt_out_ep;
    logic [1:0] csw_status_set;
    logic [1:0] control_reply;
    logic [3:0] max_lun_byte;
    logic [2:0] phase;
    logic [2:0] error_kind;
  } out_beat_t;

endpackage

/* hdl/umsc_cfg_regs.sv */
// APB register file holding the max LUN index.
module umsc_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  max_lun_index
);

  logic [3:0] max_lun_r;
  logic [3:0] max_lun_nxt;
  logic       hit;

  assign hit    = (paddr == umsc_pkg::REG_ADDR_MAX_LUN);
  assign pready = 1'b1;

  always_comb begin
    max_lun_nxt = max_lun_r;
    if (psel && penable && pwrite && hit) begin
      max_lun_nxt = pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lun_r <= 4'd0;
    end else begin
      max_lun_r <= max_lun_nxt;
    end
  end

  assign prdata        = hit ? {28'd0, max_lun_r} : 32'd0;
  assign max_lun_index = max_lun_r;

endmodule

/* hdl/umsc_step.sv */
// Next-state and result logic for one sequencer event.
module umsc_step (
  input  umsc_pkg::in_beat_t   beat,
  input  umsc_pkg::seq_state_t cur,
  input  logic [3:0]           max_lun_index,
  output umsc_pkg::seq_state_t nxt,
  output umsc_pkg::out_beat_t  res
);

  logic xfer_ok;
  logic xfer_fail;
  logic bad_len;
  logic bad_cbw;
  logic setup_zero;

  assign xfer_ok    = (beat.xfer_status == umsc_pkg::XFER_OK);
  assign xfer_fail  = !xfer_ok && (beat.xfer_status != umsc_pkg::XFER_PENDING);
  assign bad_len    = (beat.xfer_bytes != umsc_pkg::CBW_LENGTH);
  assign bad_cbw    = bad_len || (beat.cbw_signature != umsc_pkg::CBW_SIG);
  assign setup_zero = (beat.setup_value == 16'd0) && (beat.setup_index == 16'd0);

  // next state
  always_comb begin
    nxt = cur;
    unique case (beat.operation)
      umsc_pkg::OP_POLL: begin
        unique case (cur.phase)
          umsc_pkg::PH_INIT: begin
            if (beat.link_awake || beat.link_configured) begin
              nxt.phase = umsc_pkg::PH_WAIT;
            end
          end
          umsc_pkg::PH_WAIT: begin
            if (beat.link_configured) begin
              nxt.phase    = umsc_pkg::PH_READCBW;
              nxt.recovery = 1'b0;
            end
          end
          default: begin
            if (!beat.link_configured) begin
              nxt.phase = umsc_pkg::PH_INIT;
            end
          end
        endcase
      end
      umsc_pkg::OP_CMD: begin
        unique case (cur.phase)
          umsc_pkg::PH_READCBW: nxt.phase = umsc_pkg::PH_WAITCBW;
          umsc_pkg::PH_WAITCBW: begin
            if (xfer_ok && bad_cbw) begin
              nxt.phase    = umsc_pkg::PH_READCBW;
              nxt.recovery = 1'b1;
            end else if (xfer_ok) begin
              nxt.phase = umsc_pkg::PH_PROCESS;
            end else if (xfer_fail) begin
              nxt.phase = umsc_pkg::PH_READCBW;
            end
          end
          default: nxt = cur;
        endcase
      end
      umsc_pkg::OP_STATUS: begin
        unique case (cur.phase)
          umsc_pkg::PH_PROCESS: nxt.phase = umsc_pkg::PH_SENDCSW;
          umsc_pkg::PH_SENDCSW: begin
            if (!beat.in_halted) begin
              nxt.phase = umsc_pkg::PH_WAITCSW;
            end
          end
          umsc_pkg::PH_WAITCSW: begin
            if (xfer_ok || xfer_fail) begin
              nxt.phase = umsc_pkg::PH_READCBW;
            end
          end
          default: nxt = cur;
        endcase
      end
      default: begin
        if (beat.setup_request == umsc_pkg::REQ_RESET && setup_zero
            && beat.setup_length == 16'd0) begin
          nxt.phase    = umsc_pkg::PH_WAIT;
          nxt.recovery = 1'b0;
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    res       = '0;
    res.phase = nxt.phase;
    unique case (beat.operation)
      umsc_pkg::OP_POLL: begin
        if (cur.phase != umsc_pkg::PH_INIT) begin
          res.link_ready = beat.link_configured;
        end
      end
      umsc_pkg::OP_CMD: begin
        unique case (cur.phase)
          umsc_pkg::PH_READCBW: res.start_cbw_read = 1'b1;
          umsc_pkg::PH_WAITCBW: begin
            if (xfer_ok && bad_cbw) begin
              res.error_kind     = bad_len ? umsc_pkg::ERR_CBW_SIZE : umsc_pkg::ERR_CBW_SIG;
              res.halt_in_ep     = 1'b1;
              res.halt_out_ep    = 1'b1;
              res.csw_status_set = umsc_pkg::CSW_FAILED;
            end else if (xfer_ok) begin
              res.command_ready = 1'b1;
            end else if (xfer_fail) begin
              res.error_kind = umsc_pkg::ERR_CBW_READ;
            end
          end
          default: res.phase = nxt.phase;
        endcase
      end
      umsc_pkg::OP_STATUS: begin
        unique case (cur.phase)
          umsc_pkg::PH_PROCESS: begin
            res.halt_in_ep  = |(beat.command_case & umsc_pkg::CCASE_STALL_IN);
            res.halt_out_ep = |(beat.command_case & umsc_pkg::CCASE_STALL_OUT);
            if (|(beat.command_case & umsc_pkg::CCASE_PHASE_ERR)) begin
              res.csw_status_set = umsc_pkg::CSW_PHASE_ERROR;
            end
          end
          umsc_pkg::PH_SENDCSW: res.start_csw_write = !beat.in_halted;
          umsc_pkg::PH_WAITCSW: begin
            res.status_done = xfer_ok || xfer_fail;
            if (xfer_fail) begin
              res.error_kind = umsc_pkg::ERR_CSW_WRITE;
            end
          end
          default: res.phase = nxt.phase;
        endcase
      end
      default: begin
        unique case (beat.setup_request)
          umsc_pkg::REQ_CLEAR_FEATURE: begin
            if (beat.setup_value == umsc_pkg::FEAT_ENDPOINT_HALT && cur.recovery) begin
              res.control_reply = umsc_pkg::CTRL_ZLP;
            end
          end
          umsc_pkg::REQ_MAX_LUN: begin
            if (setup_zero && beat.setup_length == 16'd1) begin
              res.control_reply = umsc_pkg::CTRL_MAX_LUN;
              res.max_lun_byte  = max_lun_index;
            end else begin
              res.control_reply = umsc_pkg::CTRL_STALL;
            end
          end
          umsc_pkg::REQ_RESET: begin
            res.control_reply = (setup_zero && beat.setup_length == 16'd0)
                              ? umsc_pkg::CTRL_ZLP : umsc_pkg::CTRL_STALL;
          end
          default: res.control_reply = umsc_pkg::CTRL_NONE;
        endcase
      end
    endcase
  end

endmodule

/* hdl/usb_msc_bulk_only_sequencer_core.sv */
// Top level of the USB mass storage bulk-only transport sequencer.
// Path: a beat taken on in_ is held in the stage 1 register, then its result beat is
// written to the result register and shown on out_; out_ready low can hold it in stage 1.
// Throughput: 1 beat per cycle; the input register and the result register
// each hold one beat, so both sides run at full rate unless out_ready stalls.
// Reset (rst_n low, synchronous): phase to init, recovery flag and max LUN cleared.
module usb_msc_bulk_only_sequencer_core (
  input  logic                clk,
  input  logic                rst_n,
  // event channel
  input  logic                in_valid,
  output logic                in_ready,
  input  umsc_pkg::in_beat_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output umsc_pkg::out_beat_t out_data,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

`include "assert_macros.svh"

  // stage 1: captured event beat
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  umsc_pkg::in_beat_t   s1_data_r;

  // stage 2: result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  umsc_pkg::out_beat_t  out_data_r;

  // sequencer state: phase and reset-recovery flag
  umsc_pkg::seq_state_t st_r;
  umsc_pkg::seq_state_t st_nxt;
  umsc_pkg::out_beat_t  step_res;

  logic                 s1_adv;
  logic                 in_acc;
  logic [3:0]           max_lun_index;

  umsc_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_lun_index (max_lun_index)
  );

  umsc_step u_step (
    .beat          (s1_data_r),
    .cur           (st_r),
    .max_lun_index (max_lun_index),
    .nxt           (st_nxt),
    .res           (step_res)
  );

  // stage 1 moves on whenever the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: umsc_pkg::PH_INIT, recovery: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a beat leaving stage 1 always lands in the result register
  `UMSC_ASSERT_NEXT(a_adv_lands, s1_adv, out_valid_r && out_data_r.phase == st_r.phase, "stage 1 beat lost or phase mismatch")
  // a good CBW leaves the sequencer in process
  `UMSC_ASSERT_NOW(a_cmd_ready_phase, out_valid_r && out_data_r.command_ready, out_data_r.phase == umsc_pkg::PH_PROCESS, "command_ready outside process phase")
  // every reported error returns to reading a CBW
  `UMSC_ASSERT_NOW(a_err_phase, out_valid_r && out_data_r.error_kind != umsc_pkg::ERR_NONE, out_data_r.phase == umsc_pkg::PH_READCBW, "error without return to readcbw")
  // a bad CBW arms reset recovery
  `UMSC_ASSERT_NEXT(a_bad_cbw_recovery, s1_adv && st_r.phase == umsc_pkg::PH_WAITCBW && step_res.halt_out_ep, st_r.recovery, "bad CBW did not arm recovery")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the bulk-only transport sequencer core.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] REG_ADDR_UNUSED = 3'd4;  // beyond the last register
  localparam int         CLK_HALF = 5;
  localparam int         IDLE_PCT = 34;
  localparam int         HOLD_CYCLES = 80;        // long receiver stall
  localparam int         HOLD_AFTER = 300;        // beats seen before the stall
  localparam int         DRAIN_CYCLES = 4;        // two-stage latency plus margin

  // Scoreboard: keeps its own copy of the phase register, the recovery flag
  // and the max LUN register, and queues one expected reply per event beat.
  class bot_scoreboard;
    umsc_pkg::phase_t    phase;
    bit                  recovery;
    logic [3:0]          max_lun;
    umsc_pkg::out_beat_t expected_replies[$];
    int                  mismatches;
    int                  received;

    function new();
      phase = umsc_pkg::PH_INIT;
      recovery = 1'b0;
      max_lun = '0;
      mismatches = 0;
      received = 0;
    endfunction

    // One event through the sequencer; returns the reply it must give.
    function umsc_pkg::out_beat_t advance_sequencer(umsc_pkg::in_beat_t b);
      umsc_pkg::out_beat_t r;
      bit                  xfer_failed;
      r = '0;
      xfer_failed = (b.xfer_status != umsc_pkg::XFER_OK) &&
                    (b.xfer_status != umsc_pkg::XFER_PENDING);
      case (b.operation)
        umsc_pkg::OP_POLL: begin
          if (phase == umsc_pkg::PH_INIT) begin
            if (b.link_awake || b.link_configured) phase = umsc_pkg::PH_WAIT;
          end else if (phase == umsc_pkg::PH_WAIT) begin
            if (b.link_configured) begin
              phase = umsc_pkg::PH_READCBW;
              recovery = 1'b0;
              r.link_ready = 1'b1;
            end
          end else if (b.link_configured) begin
            r.link_ready = 1'b1;
          end else begin
            phase = umsc_pkg::PH_INIT;
          end
        end
        umsc_pkg::OP_CMD: begin
          if (phase == umsc_pkg::PH_READCBW) begin
            r.start_cbw_read = 1'b1;
            phase = umsc_pkg::PH_WAITCBW;
          end else if (phase == umsc_pkg::PH_WAITCBW) begin
            if (b.xfer_status == umsc_pkg::XFER_OK) begin
              if (b.xfer_bytes != umsc_pkg::CBW_LENGTH ||
                  b.cbw_signature != umsc_pkg::CBW_SIG) begin
                // invalid CBW: halt both endpoints, fail, back to reading
                r.error_kind = (b.xfer_bytes != umsc_pkg::CBW_LENGTH) ?
                               umsc_pkg::ERR_CBW_SIZE : umsc_pkg::ERR_CBW_SIG;
                r.halt_in_ep = 1'b1;
                r.halt_out_ep = 1'b1;
                r.csw_status_set = umsc_pkg::CSW_FAILED;
                recovery = 1'b1;
                phase = umsc_pkg::PH_READCBW;
              end else begin
                r.command_ready = 1'b1;
                phase = umsc_pkg::PH_PROCESS;
              end
            end else if (xfer_failed) begin
              r.error_kind = umsc_pkg::ERR_CBW_READ;
              phase = umsc_pkg::PH_READCBW;
            end
          end
        end
        umsc_pkg::OP_STATUS: begin
          if (phase == umsc_pkg::PH_PROCESS) begin
            r.halt_in_ep = |(b.command_case & umsc_pkg::CCASE_STALL_IN);
            r.halt_out_ep = |(b.command_case & umsc_pkg::CCASE_STALL_OUT);
            if (|(b.command_case & umsc_pkg::CCASE_PHASE_ERR))
              r.csw_status_set = umsc_pkg::CSW_PHASE_ERROR;
            phase = umsc_pkg::PH_SENDCSW;
          end else if (phase == umsc_pkg::PH_SENDCSW) begin
            if (!b.in_halted) begin
              r.start_csw_write = 1'b1;
              phase = umsc_pkg::PH_WAITCSW;
            end
          end else if (phase == umsc_pkg::PH_WAITCSW) begin
            if (b.xfer_status == umsc_pkg::XFER_OK) begin
              r.status_done = 1'b1;
              phase = umsc_pkg::PH_READCBW;
            end else if (xfer_failed) begin
              r.error_kind = umsc_pkg::ERR_CSW_WRITE;
              r.status_done = 1'b1;
              phase = umsc_pkg::PH_READCBW;
            end
          end
        end
        default: begin
          if (b.setup_request == umsc_pkg::REQ_CLEAR_FEATURE) begin
            if (b.setup_value == umsc_pkg::FEAT_ENDPOINT_HALT && recovery)
              r.control_reply = umsc_pkg::CTRL_ZLP;
          end else if (b.setup_request == umsc_pkg::REQ_MAX_LUN) begin
            if (b.setup_value == 0 && b.setup_index == 0 && b.setup_length == 1) begin
              r.control_reply = umsc_pkg::CTRL_MAX_LUN;
              r.max_lun_byte = max_lun;
            end else begin
              r.control_reply = umsc_pkg::CTRL_STALL;
            end
          end else if (b.setup_request == umsc_pkg::REQ_RESET) begin
            if (b.setup_value == 0 && b.setup_index == 0 && b.setup_length == 0) begin
              phase = umsc_pkg::PH_WAIT;
              recovery = 1'b0;
              r.control_reply = umsc_pkg::CTRL_ZLP;
            end else begin
              r.control_reply = umsc_pkg::CTRL_STALL;
            end
          end
        end
      endcase
      r.phase = phase;
      return r;
    endfunction

    function void note_event(umsc_pkg::in_beat_t b);
      expected_replies.push_back(advance_sequencer(b));
    endfunction

    function bit differs(string field, logic [31:0] want, logic [31:0] got);
      if (got === want) return 0;
      if (mismatches < 10)
        $display("%0t: reply %0d field %s expected %0h got %0h", $time, received, field,
                 want, got);
      return 1;
    endfunction

    function void check_reply(umsc_pkg::out_beat_t got);
      umsc_pkg::out_beat_t want;
      bit                  bad;
      received++;
      if (expected_replies.size() == 0) begin
        if (mismatches < 10) $display("%0t: reply beat with no event outstanding", $time);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      bad = 0;
      bad |= differs("link_ready", 32'(want.link_ready), 32'(got.link_ready));
      bad |= differs("command_ready", 32'(want.command_ready), 32'(got.command_ready));
      bad |= differs("status_done", 32'(want.status_done), 32'(got.status_done));
      bad |= differs("start_cbw_read", 32'(want.start_cbw_read), 32'(got.start_cbw_read));
      bad |= differs("start_csw_write", 32'(want.start_csw_write),
                     32'(got.start_csw_write));
      bad |= differs("halt_in_ep", 32'(want.halt_in_ep), 32'(got.halt_in_ep));
      bad |= differs("halt_out_ep", 32'(want.halt_out_ep), 32'(got.halt_out_ep));
      bad |= differs("csw_status_set", 32'(want.csw_status_set), 32'(got.csw_status_set));
      bad |= differs("control_reply", 32'(want.control_reply), 32'(got.control_reply));
      bad |= differs("max_lun_byte", 32'(want.max_lun_byte), 32'(got.max_lun_byte));
      bad |= differs("phase", 32'(want.phase), 32'(got.phase));
      bad |= differs("error_kind", 32'(want.error_kind), 32'(got.error_kind));
      if (bad) mismatches++;
    endfunction

    function void check_reg(logic [31:0] got);
      if (got !== {28'd0, max_lun}) begin
        if (mismatches < 10)
          $display("%0t: max LUN readback expected %0h got %0h", $time, max_lun, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  umsc_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  umsc_pkg::out_beat_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  bot_scoreboard sb = new();
  bit            no_idle = 0;   // set for a stretch with full-rate traffic

  usb_msc_bulk_only_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Every field filled at random, then the opcode forced.
  function automatic umsc_pkg::in_beat_t rand_beat(logic [1:0] op);
    umsc_pkg::in_beat_t b;
    b.operation       = op;
    b.link_awake      = 1'($urandom_range(1));
    b.link_configured = 1'($urandom_range(1));
    b.xfer_status     = 3'($urandom_range(7));
    b.xfer_bytes      = 16'($urandom);
    b.cbw_signature   = $urandom;
    b.command_case    = 3'($urandom_range(7));
    b.in_halted       = 1'($urandom_range(1));
    b.setup_request   = 8'($urandom);
    b.setup_value     = 16'($urandom);
    b.setup_index     = 16'($urandom);
    b.setup_length    = 16'($urandom);
    return b;
  endfunction

  function automatic umsc_pkg::in_beat_t setup_beat(logic [7:0] req, logic [15:0] val,
                                                    logic [15:0] idx, logic [15:0] len);
    umsc_pkg::in_beat_t b;
    b = rand_beat(umsc_pkg::OP_SETUP);
    b.setup_request = req;
    b.setup_value   = val;
    b.setup_index   = idx;
    b.setup_length  = len;
    return b;
  endfunction

  function automatic umsc_pkg::in_beat_t good_cbw();
    umsc_pkg::in_beat_t b;
    b = rand_beat(umsc_pkg::OP_CMD);
    b.xfer_status   = umsc_pkg::XFER_OK;
    b.xfer_bytes    = umsc_pkg::CBW_LENGTH;
    b.cbw_signature = umsc_pkg::CBW_SIG;
    return b;
  endfunction

  function automatic umsc_pkg::in_beat_t poll_beat(logic awake, logic configured);
    umsc_pkg::in_beat_t b;
    b = rand_beat(umsc_pkg::OP_POLL);
    b.link_awake      = awake;
    b.link_configured = configured;
    return b;
  endfunction

  // Control requests: mostly well-formed, some with one field spoilt.
  function automatic umsc_pkg::in_beat_t rand_setup();
    umsc_pkg::in_beat_t b;
    int                 pick;
    pick = $urandom_range(3);
    case (pick)
      0: b = setup_beat(umsc_pkg::REQ_CLEAR_FEATURE, umsc_pkg::FEAT_ENDPOINT_HALT,
                        16'($urandom), 16'($urandom));
      1: b = setup_beat(umsc_pkg::REQ_MAX_LUN, 16'd0, 16'd0, 16'd1);
      2: b = setup_beat(umsc_pkg::REQ_RESET, 16'd0, 16'd0, 16'd0);
      default: b = rand_beat(umsc_pkg::OP_SETUP);
    endcase
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(2))
        0: b.setup_value  = 16'($urandom_range(1, 16'hFFFF));
        1: b.setup_index  = 16'($urandom_range(1, 16'hFFFF));
        default: b.setup_length = 16'($urandom_range(2, 16'hFFFF));
      endcase
    end
    return b;
  endfunction

  // Next random event, chosen from the predicted phase so that most traffic
  // walks the full CBW / data / CSW cycle with random content.
  function automatic umsc_pkg::in_beat_t next_event();
    umsc_pkg::in_beat_t b;
    int                 roll;
    int                 sub;
    roll = $urandom_range(99);
    sub  = $urandom_range(99);
    if (roll < 12) return rand_beat(2'($urandom_range(3)));
    if (roll < 20) return rand_setup();
    if (roll < 24) return rand_beat(umsc_pkg::OP_POLL);
    case (sb.phase)
      umsc_pkg::PH_INIT: begin
        b = rand_beat(umsc_pkg::OP_POLL);
        if (!b.link_awake) b.link_configured = 1'b1;
      end
      umsc_pkg::PH_WAIT: begin
        b = rand_beat(umsc_pkg::OP_POLL);
        b.link_configured = (sub < 90);
      end
      umsc_pkg::PH_READCBW: b = rand_beat(umsc_pkg::OP_CMD);
      umsc_pkg::PH_WAITCBW: begin
        if (sub < 15) begin
          b = rand_beat(umsc_pkg::OP_CMD);
          b.xfer_status = umsc_pkg::XFER_PENDING;
        end else if (sub < 75) begin
          b = good_cbw();
        end else if (sub < 87) begin
          b = good_cbw();
          if ($urandom_range(1)) b.xfer_bytes = 16'($urandom);
          else b.cbw_signature = $urandom;
        end else begin
          b = rand_beat(umsc_pkg::OP_CMD);
          b.xfer_status = 3'($urandom_range(2, 7));
        end
      end
      umsc_pkg::PH_PROCESS: b = rand_beat(umsc_pkg::OP_STATUS);
      umsc_pkg::PH_SENDCSW: begin
        b = rand_beat(umsc_pkg::OP_STATUS);
        b.in_halted = (sub < 25);
      end
      default: begin
        b = rand_beat(umsc_pkg::OP_STATUS);
        if (sub < 15) b.xfer_status = umsc_pkg::XFER_PENDING;
        else if (sub < 85) b.xfer_status = umsc_pkg::XFER_OK;
        else b.xfer_status = 3'($urandom_range(2, 7));
      end
    endcase
    return b;
  endfunction

  // Offer one event beat, with random idle cycles ahead of it, and hold it
  // until the core takes it. Called and returns at a rising edge.
  task automatic send_beat(umsc_pkg::in_beat_t b);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_event(b);
  endtask

  // Sender stops and waits until every reply is back and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == umsc_pkg::REG_ADDR_MAX_LUN) sb.max_lun = data[3:0];
  endtask

  task automatic reg_read_check(logic [2:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_reg(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_events(int count);
    repeat (count) send_beat(next_event());
  endtask

  // Receiver: checks each reply beat, stalls at random, and once holds off
  // for a long stretch so the core fills and pushes back on its input.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 0;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_reply(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && sb.received >= HOLD_AFTER) begin
        held = 1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Safety net for a hung handshake.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // max LUN must come out of reset as zero
    reg_read_check(umsc_pkg::REG_ADDR_MAX_LUN);

    // -- directed: idle steps, control requests, full cycle, all failure paths
    send_beat(rand_beat(umsc_pkg::OP_CMD));       // nothing to do in init
    send_beat(rand_beat(umsc_pkg::OP_STATUS));
    send_beat(setup_beat(umsc_pkg::REQ_CLEAR_FEATURE, umsc_pkg::FEAT_ENDPOINT_HALT,
                         16'd0, 16'd0));          // no recovery
    send_beat(setup_beat(umsc_pkg::REQ_MAX_LUN, 16'd0, 16'd0, 16'd1));
    send_beat(setup_beat(umsc_pkg::REQ_MAX_LUN, 16'd0, 16'd0, 16'hFFFF));  // stalled
    send_beat(setup_beat(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF));            // unknown
    send_beat(poll_beat(1'b0, 1'b0));
    send_beat(poll_beat(1'b1, 1'b0));   // to wait
    send_beat(poll_beat(1'b1, 1'b0));
    send_beat(poll_beat(1'b0, 1'b1));   // to readcbw
    send_beat(rand_beat(umsc_pkg::OP_STATUS));    // nothing to do in readcbw
    send_beat(rand_beat(umsc_pkg::OP_CMD));
    begin
      umsc_pkg::in_beat_t b;
      b = rand_beat(umsc_pkg::OP_CMD);
      b.xfer_status = umsc_pkg::XFER_PENDING;
      send_beat(b);
      b.xfer_status = 3'd7;             // top failure code
      send_beat(b);
      send_beat(rand_beat(umsc_pkg::OP_CMD));
      b = good_cbw();
      b.xfer_bytes = 16'hFFFF;          // wrong length
      send_beat(b);
      send_beat(rand_beat(umsc_pkg::OP_CMD));
      b = good_cbw();
      b.cbw_signature = 32'hFFFF_FFFF;  // wrong signature
      send_beat(b);
      send_beat(setup_beat(umsc_pkg::REQ_CLEAR_FEATURE, umsc_pkg::FEAT_ENDPOINT_HALT,
                           16'hFFFF, 16'd0));
      send_beat(setup_beat(umsc_pkg::REQ_CLEAR_FEATURE, 16'hFFFF, 16'd0, 16'd0));
      send_beat(setup_beat(umsc_pkg::REQ_RESET, 16'd0, 16'd0, 16'hFFFF));  // stalled
      send_beat(setup_beat(umsc_pkg::REQ_RESET, 16'd0, 16'd0, 16'd0));     // back to wait
      send_beat(poll_beat(1'b1, 1'b1));
      send_beat(rand_beat(umsc_pkg::OP_CMD));
      send_beat(good_cbw());
      b = rand_beat(umsc_pkg::OP_STATUS);
      b.command_case = umsc_pkg::CCASE_STALL_IN | umsc_pkg::CCASE_STALL_OUT |
                       umsc_pkg::CCASE_PHASE_ERR;
      send_beat(b);
      b.in_halted = 1'b1;               // CSW held back
      send_beat(b);
      b.in_halted = 1'b0;
      send_beat(b);
      b.xfer_status = 3'd2;             // CSW write lost
      send_beat(b);
    end
    drain();

    // -- random phases, each after a fresh max LUN write
    reg_write(umsc_pkg::REG_ADDR_MAX_LUN, {$urandom} | 32'hF);
    reg_write(REG_ADDR_UNUSED, $urandom);      // must leave max LUN alone
    reg_read_check(umsc_pkg::REG_ADDR_MAX_LUN);
    random_events(300);
    drain();

    reg_write(umsc_pkg::REG_ADDR_MAX_LUN, {$urandom} & ~32'hF);
    reg_read_check(umsc_pkg::REG_ADDR_MAX_LUN);
    no_idle = 1;
    random_events(300);
    drain();
    no_idle = 0;

    reg_write(umsc_pkg::REG_ADDR_MAX_LUN, $urandom);
    reg_read_check(umsc_pkg::REG_ADDR_MAX_LUN);
    random_events(350);
    drain();

    reg_write(umsc_pkg::REG_ADDR_MAX_LUN, 32'hF);
    reg_read_check(umsc_pkg::REG_ADDR_MAX_LUN);
    random_events(300);
    drain();

    if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
